// ----- rtl/core/sbpd_pkg.sv -----
// sbpd_pkg: constants, command type and helper function for the bar peak unit
// used by every module of the block; depends on nothing
`default_nettype none

package sbpd_pkg;

	localparam int LAST_COLUMN  = 15;
	localparam int TOP_ROW      = 31;
	localparam int ROW_MAX      = 31;
	localparam int TOP_LIMIT    = (TOP_ROW > ROW_MAX) ? ROW_MAX : TOP_ROW;
	localparam int PEAK_DEPTH   = 16;
	localparam int PALETTE_SIZE = 10;

	localparam int COL_W   = 4;
	localparam int LEVEL_W = 8;
	localparam int ROW_W   = 5;
	localparam int SLOT_W  = 4;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one bar update as seen by the write sequencer
	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  first_row;
		logic [ROW_W-1:0]  last_row;
		logic              lit;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	// column is below twice the palette size, so one compare and subtract
	function automatic logic [SLOT_W-1:0] col_mod_palette(input logic [COL_W-1:0] c);
		logic [SLOT_W-1:0] r;
		if (c >= COL_W'(PALETTE_SIZE)) begin
			r = SLOT_W'(c - COL_W'(PALETTE_SIZE));
		end else begin
			r = SLOT_W'(c);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sbpd_if.sv -----
// sbpd_in_if and sbpd_out_if: valid/ready channels for bar levels and pixel writes
// depends on sbpd_pkg for field widths
`default_nettype none

interface sbpd_in_if
	import sbpd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [COL_W-1:0]   column;
	logic [LEVEL_W-1:0] level;

	modport source (output valid, output column, output level, input ready);
	modport sink (input valid, input column, input level, output ready);
endinterface

interface sbpd_out_if
	import sbpd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  pixel_column;
	logic [ROW_W-1:0]  pixel_row;
	logic              lit;
	logic [SLOT_W-1:0] color_slot;
	logic              last;

	modport source (output valid, output pixel_column, output pixel_row, output lit,
		output color_slot, output last, input ready);
	modport sink (input valid, input pixel_column, input pixel_row, input lit,
		input color_slot, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sbpd_front.sv -----
// sbpd_front: takes bar levels, holds the peak row per column, classifies each
// level as rising or falling and issues a command; depends on sbpd_pkg, sbpd_if
`default_nettype none

module sbpd_front
	import sbpd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sbpd_in_if.sink    lvl,
	output logic       cmd_valid,
	input  wire logic  cmd_ready,
	output cmd_t       cmd
);

	logic [ROW_W-1:0] peak_q [PEAK_DEPTH];
	logic [ROW_W-1:0] peak;
	logic             col_ok;
	logic             rising;
	logic             accept;

	assign lvl.ready = cmd_ready;
	assign accept    = lvl.valid && cmd_ready;
	assign col_ok    = ({2'b00, lvl.column} <= 6'(LAST_COLUMN));
	assign peak      = peak_q[lvl.column];
	assign rising    = (lvl.level > {3'b000, peak}) && (lvl.level <= LEVEL_W'(TOP_LIMIT));

	// ignored columns produce no command and leave the peaks alone
	assign cmd_valid = lvl.valid && col_ok;

	always_comb begin
		cmd.column    = lvl.column;
		cmd.first_row = peak;
		if (rising) begin
			cmd.last_row = ROW_W'(lvl.level[ROW_W-1:0] - ROW_W'(1));
			cmd.lit      = 1'b1;
			cmd.slot     = col_mod_palette(lvl.column);
		end else begin
			cmd.last_row = peak;
			cmd.lit      = 1'b0;
			cmd.slot     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PEAK_DEPTH; i++) begin
				peak_q[i] <= '0;
			end
		end else if (accept && col_ok) begin
			if (rising) begin
				peak_q[lvl.column] <= lvl.level[ROW_W-1:0];
			end else if (peak != '0) begin
				peak_q[lvl.column] <= peak - ROW_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sbpd_fifo.sv -----
// sbpd_fifo: short command queue between the classifier and the write sequencer
// depends on sbpd_pkg
`default_nettype none

module sbpd_fifo
	import sbpd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire cmd_t  push_cmd,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output cmd_t       pop_cmd
);

	cmd_t              entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sbpd_back.sv -----
// sbpd_back: steps through the rows of one command and drives pixel writes
// from registers; depends on sbpd_pkg, sbpd_if
`default_nettype none

module sbpd_back
	import sbpd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	output logic       cmd_ready,
	input  wire cmd_t  cmd,
	sbpd_out_if.source pix
);

	logic             busy_q;
	cmd_t             cur_q;
	logic [ROW_W-1:0] row_q;
	logic             at_end;
	logic             take;

	assign at_end    = (row_q == cur_q.last_row);
	assign take      = pix.valid && pix.ready;
	// load the next command when idle or as the final word leaves
	assign cmd_ready = !busy_q || (take && at_end);

	assign pix.valid        = busy_q;
	assign pix.pixel_column = cur_q.column;
	assign pix.pixel_row    = row_q;
	assign pix.lit          = cur_q.lit;
	assign pix.color_slot   = cur_q.slot;
	assign pix.last         = at_end;

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (cmd_ready) begin
			busy_q <= cmd_valid;
			row_q  <= cmd.first_row;
		end else if (take) begin
			row_q <= row_q + ROW_W'(1);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/spectrum_bar_peak_decay_unit.sv -----
// channel  dir  payload                                           word
// lvl      in   column[3:0] level[7:0]                           one bar level
// pix      out  pixel_column[3:0] pixel_row[4:0] lit color_slot[3:0] last  one pixel write
//
// a level is taken when the command queue has room; the sequencer then
// emits one word per cycle while pix is not stalled: (level - held peak)
// words for a rising bar, one word for a falling bar, so 1 to 31 words per item
// reset clears all held peaks to row 0 and empties the queue and sequencer
// either side may stall independently; the queue holds two pending commands
//
// top level of the bar peak hold unit; depends on sbpd_pkg, sbpd_if,
// sbpd_front, sbpd_fifo, sbpd_back
`default_nettype none

module spectrum_bar_peak_decay_unit
	import sbpd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	sbpd_in_if.sink    lvl,
	sbpd_out_if.source pix
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	sbpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.lvl       (lvl),
		.cmd_valid (push_valid),
		.cmd_ready (push_ready),
		.cmd       (push_cmd)
	);

	sbpd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	sbpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.pix       (pix)
	);

endmodule

`default_nettype wire

// ----- rtl/core/sbpd_checker.sv -----
// sbpd_checker: port-level checks on the pixel write stream, bound to the top
// depends on sbpd_pkg and the top level spectrum_bar_peak_decay_unit
`default_nettype none

module sbpd_checker
	import sbpd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [COL_W-1:0]  out_column,
	input wire logic [ROW_W-1:0]  out_row,
	input wire logic              out_lit,
	input wire logic [SLOT_W-1:0] out_slot,
	input wire logic              out_last
);

	// a stalled word keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_column) && $stable(out_row)
			&& $stable(out_lit) && $stable(out_slot) && $stable(out_last))
		else $error("pixel word changed while stalled");

	// an off write is a single word with no color
	a_off_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_lit |-> out_last && (out_slot == '0))
		else $error("off write not single or colored");

	// a rising run continues on the next row of the same column right away
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_lit
			&& (out_column == $past(out_column))
			&& (out_row == $past(out_row) + ROW_W'(1)))
		else $error("rising run broken");

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_lit |-> (out_slot < SLOT_W'(PALETTE_SIZE))
			&& (out_row < ROW_W'(TOP_LIMIT)))
		else $error("palette slot or row out of range");

endmodule

bind spectrum_bar_peak_decay_unit sbpd_checker u_sbpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (pix.valid),
	.out_ready  (pix.ready),
	.out_column (pix.pixel_column),
	.out_row    (pix.pixel_row),
	.out_lit    (pix.lit),
	.out_slot   (pix.color_slot),
	.out_last   (pix.last)
);

`default_nettype wire
